@@ rtl/pqrr_pkg.sv @@
// Shared constants, types and codes for the round-robin scheduler.
package pqrr_pkg;

  localparam int SLOT_COUNT    = 64;
  localparam int CONTEXT_WIDTH = 48;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int SLOT_IN_W     = 6;
  localparam int PRIO_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int SEARCH_LANES  = 8;
  localparam int SEARCH_GROUPS = (SLOT_COUNT + SEARCH_LANES - 1) / SEARCH_LANES;
  localparam int GRP_W         = (SEARCH_GROUPS > 1) ? $clog2(SEARCH_GROUPS) : 1;
  localparam int CAND_W        = SLOT_W + 4;

  typedef logic [SLOT_W-1:0]           slot_idx_t;
  typedef logic [SLOT_IN_W-1:0]        slot_in_t;
  typedef logic signed [PRIO_W-1:0]    prio_t;
  typedef logic [CONTEXT_WIDTH-1:0]    ctx_t;
  typedef logic [GRP_W-1:0]            grp_t;
  typedef logic [CAND_W-1:0]           cand_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_BLOCK   = 3'd1,
    OP_UNBLOCK = 3'd2,
    OP_KILL    = 3'd3,
    OP_SETPRIO = 3'd4,
    OP_SWITCH  = 3'd5,
    OP_YIELD   = 3'd6,
    OP_QUERY   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SEL_READ,
    S_SEL_LOAD,
    S_OUT_READ,
    S_RESPOND
  } state_e;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_KILLED  = 2'd3;

  localparam cfg_idx_t CFG_BEST    = 2'd0;
  localparam cfg_idx_t CFG_WORST   = 2'd1;
  localparam cfg_idx_t CFG_DEFAULT = 2'd2;

  localparam prio_t BEST_RST    = 8'sd0;
  localparam prio_t WORST_RST   = 8'sd8;
  localparam prio_t DEFAULT_RST = 8'sd4;

  typedef struct packed {
    logic latch;
    logic exec;
    logic search;
    logic sel_read;
    logic sel_load;
    logic out_read;
    logic respond;
  } dp_cmd_t;

  typedef struct packed {
    logic need_search;
    logic found;
    logic last_group;
  } dp_stat_t;

endpackage

@@ rtl/pqrr_ram.sv @@
// Generic single-port RAM with registered read.
module pqrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/pqrr_ctrl.sv @@
// Scheduler sequencer: steps each item through execute, search and readout.
module pqrr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pqrr_pkg::dp_stat_t stat_i,
  output pqrr_pkg::dp_cmd_t  cmd_o,
  output logic              done_o
);

  pqrr_pkg::state_e state_q, state_d;
  logic             done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqrr_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != pqrr_pkg::S_IDLE);
    done_d  = (state_q == pqrr_pkg::S_RESPOND);
    case (state_q)
      pqrr_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = pqrr_pkg::S_EXEC;
        end
      end
      pqrr_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_search ? pqrr_pkg::S_SEARCH : pqrr_pkg::S_OUT_READ;
      end
      pqrr_pkg::S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (stat_i.found) begin
          state_d = pqrr_pkg::S_SEL_READ;
        end else if (stat_i.last_group) begin
          state_d = pqrr_pkg::S_OUT_READ;
        end
      end
      pqrr_pkg::S_SEL_READ: begin
        cmd_o.sel_read = 1'b1;
        state_d        = pqrr_pkg::S_SEL_LOAD;
      end
      pqrr_pkg::S_SEL_LOAD: begin
        cmd_o.sel_load = 1'b1;
        state_d        = pqrr_pkg::S_OUT_READ;
      end
      pqrr_pkg::S_OUT_READ: begin
        cmd_o.out_read = 1'b1;
        state_d        = pqrr_pkg::S_RESPOND;
      end
      pqrr_pkg::S_RESPOND: begin
        cmd_o.respond = 1'b1;
        state_d       = pqrr_pkg::S_IDLE;
      end
      default: begin
        state_d = pqrr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pqrr_dp.sv @@
// Scheduler datapath: slot marks, current task, quantum, search lanes and RAMs.
module pqrr_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pqrr_pkg::dp_cmd_t        cmd_i,
  output pqrr_pkg::dp_stat_t       stat_o,
  input  logic                     cfg_we_i,
  input  pqrr_pkg::cfg_idx_t       cfg_index_i,
  input  pqrr_pkg::prio_t          cfg_data_i,
  input  logic [2:0]               opcode_i,
  input  pqrr_pkg::slot_in_t       slot_i,
  input  pqrr_pkg::prio_t          priority_req_i,
  input  pqrr_pkg::ctx_t           context_req_i,
  output logic                     failed_o,
  output pqrr_pkg::ctx_t           resume_context_o,
  output logic                     running_valid_o,
  output pqrr_pkg::slot_in_t       running_slot_o,
  output logic                     slot_active_o,
  output logic [1:0]               slot_status_o,
  output pqrr_pkg::prio_t          slot_priority_o
);

  localparam int SC   = pqrr_pkg::SLOT_COUNT;
  localparam int WIDE = pqrr_pkg::SLOT_W + pqrr_pkg::SLOT_IN_W;

  // latched item
  pqrr_pkg::op_e      op_q;
  pqrr_pkg::slot_in_t slot_q;
  pqrr_pkg::prio_t    preq_q;
  pqrr_pkg::ctx_t     ctx_q;

  // configuration
  pqrr_pkg::prio_t best_q, best_d, worst_q, worst_d, dflt_q, dflt_d;

  // scheduler state
  logic [SC-1:0]       valid_q, valid_d, ready_q, ready_d, blocked_q, blocked_d;
  logic                cur_valid_q, cur_valid_d;
  pqrr_pkg::slot_idx_t cur_slot_q, cur_slot_d;
  logic [7:0]          quantum_q, quantum_d;
  pqrr_pkg::ctx_t      idle_ctx_q, idle_ctx_d;

  // per-item working registers
  pqrr_pkg::slot_idx_t base_q, base_d;
  pqrr_pkg::grp_t      grp_q, grp_d;
  logic                fail_q, fail_d;
  pqrr_pkg::ctx_t      resume_q, resume_d;

  // result registers
  logic               res_failed_q, res_failed_d;
  pqrr_pkg::ctx_t     res_resume_q, res_resume_d;
  logic               res_rvalid_q, res_rvalid_d;
  pqrr_pkg::slot_in_t res_rslot_q, res_rslot_d;
  logic               res_active_q, res_active_d;
  logic [1:0]         res_status_q, res_status_d;
  pqrr_pkg::prio_t    res_prio_q, res_prio_d;

  // RAM ports
  logic                prio_we, ctx_we;
  pqrr_pkg::slot_idx_t prio_addr, ctx_addr;
  pqrr_pkg::prio_t     prio_wdata, prio_rd;
  pqrr_pkg::ctx_t      ctx_rd;

  // decode
  logic [WIDE-1:0]     slot_wide;
  logic                inrange, active, is_switch, cur_running, cur_hit, preq_ok;
  pqrr_pkg::slot_idx_t si;
  logic signed [pqrr_pkg::PRIO_W:0] qdiff;
  logic [7:0]          qsat;

  // search lanes
  pqrr_pkg::cand_t     cand [pqrr_pkg::SEARCH_LANES];
  pqrr_pkg::cand_t     csum [pqrr_pkg::SEARCH_LANES];
  pqrr_pkg::cand_t     cidx [pqrr_pkg::SEARCH_LANES];
  logic [pqrr_pkg::SEARCH_LANES-1:0] hit;
  logic                found;
  pqrr_pkg::slot_idx_t found_idx;

  assign slot_wide   = {{pqrr_pkg::SLOT_W{1'b0}}, slot_q};
  assign inrange     = slot_wide < WIDE'(SC);
  assign si          = slot_wide[pqrr_pkg::SLOT_W-1:0];
  assign active      = inrange && valid_q[si];
  assign is_switch   = (op_q == pqrr_pkg::OP_SWITCH) || (op_q == pqrr_pkg::OP_YIELD);
  assign cur_running = valid_q[cur_slot_q] && !ready_q[cur_slot_q] && !blocked_q[cur_slot_q];
  assign cur_hit     = cur_valid_q && (cur_slot_q == si);
  assign preq_ok     = (preq_q >= best_q) && (preq_q <= worst_q);

  assign qdiff = {worst_q[pqrr_pkg::PRIO_W-1], worst_q} - {prio_rd[pqrr_pkg::PRIO_W-1], prio_rd};
  assign qsat  = qdiff[pqrr_pkg::PRIO_W] ? 8'd0 : qdiff[pqrr_pkg::PRIO_W-1:0];

  always_comb begin
    for (int j = 0; j < pqrr_pkg::SEARCH_LANES; j++) begin
      cand[j] = pqrr_pkg::cand_t'(grp_q) * pqrr_pkg::cand_t'(pqrr_pkg::SEARCH_LANES)
              + pqrr_pkg::cand_t'(j + 1);
      csum[j] = pqrr_pkg::cand_t'(base_q) + cand[j];
      cidx[j] = (csum[j] >= pqrr_pkg::cand_t'(SC)) ? csum[j] - pqrr_pkg::cand_t'(SC) : csum[j];
      hit[j]  = (cand[j] <= pqrr_pkg::cand_t'(SC))
             && ready_q[cidx[j][pqrr_pkg::SLOT_W-1:0]];
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < pqrr_pkg::SEARCH_LANES; j++) begin
      if (hit[j] && !found) begin
        found     = 1'b1;
        found_idx = cidx[j][pqrr_pkg::SLOT_W-1:0];
      end
    end
  end

  assign stat_o.need_search = is_switch &&
                              ((op_q == pqrr_pkg::OP_YIELD) || (quantum_q == 8'd0) || !cur_valid_q);
  assign stat_o.found       = found;
  assign stat_o.last_group  = (grp_q == pqrr_pkg::grp_t'(pqrr_pkg::SEARCH_GROUPS - 1));

  // RAM control
  always_comb begin
    prio_we    = cmd_i.exec &&
                 (((op_q == pqrr_pkg::OP_CREATE) && inrange) ||
                  ((op_q == pqrr_pkg::OP_SETPRIO) && active && preq_ok));
    prio_wdata = ((op_q == pqrr_pkg::OP_CREATE) && !preq_ok) ? dflt_q : preq_q;
    prio_addr  = cmd_i.sel_read ? cur_slot_q : si;
    ctx_we     = cmd_i.exec &&
                 (((op_q == pqrr_pkg::OP_CREATE) && inrange) || (is_switch && cur_valid_q));
    ctx_addr   = (cmd_i.sel_read || is_switch) ? cur_slot_q : si;
  end

  pqrr_ram #(
    .WIDTH (pqrr_pkg::PRIO_W),
    .DEPTH (SC)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .addr_i  (prio_addr),
    .wdata_i (prio_wdata),
    .rdata_o (prio_rd)
  );

  pqrr_ram #(
    .WIDTH (pqrr_pkg::CONTEXT_WIDTH),
    .DEPTH (SC)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ctx_we),
    .addr_i  (ctx_addr),
    .wdata_i (ctx_q),
    .rdata_o (ctx_rd)
  );

  always_comb begin
    best_d       = best_q;
    worst_d      = worst_q;
    dflt_d       = dflt_q;
    valid_d      = valid_q;
    ready_d      = ready_q;
    blocked_d    = blocked_q;
    cur_valid_d  = cur_valid_q;
    cur_slot_d   = cur_slot_q;
    quantum_d    = quantum_q;
    idle_ctx_d   = idle_ctx_q;
    base_d       = base_q;
    grp_d        = grp_q;
    fail_d       = fail_q;
    resume_d     = resume_q;
    res_failed_d = res_failed_q;
    res_resume_d = res_resume_q;
    res_rvalid_d = res_rvalid_q;
    res_rslot_d  = res_rslot_q;
    res_active_d = res_active_q;
    res_status_d = res_status_q;
    res_prio_d   = res_prio_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        pqrr_pkg::CFG_BEST:    best_d  = cfg_data_i;
        pqrr_pkg::CFG_WORST:   worst_d = cfg_data_i;
        pqrr_pkg::CFG_DEFAULT: dflt_d  = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.latch) begin
      resume_d = '0;
    end

    if (cmd_i.exec) begin
      case (op_q)
        pqrr_pkg::OP_CREATE: begin
          fail_d = !inrange;
          if (inrange) begin
            valid_d[si]   = 1'b1;
            ready_d[si]   = 1'b1;
            blocked_d[si] = 1'b0;
          end
        end
        pqrr_pkg::OP_BLOCK: begin
          fail_d = !active;
          if (active) begin
            ready_d[si]   = 1'b0;
            blocked_d[si] = 1'b1;
            if (cur_hit) begin
              quantum_d = 8'd0;
            end
          end
        end
        pqrr_pkg::OP_UNBLOCK: begin
          fail_d = !active;
          if (active && blocked_q[si]) begin
            blocked_d[si] = 1'b0;
            ready_d[si]   = 1'b1;
          end
        end
        pqrr_pkg::OP_KILL: begin
          fail_d = !active;
          if (active) begin
            valid_d[si]   = 1'b0;
            ready_d[si]   = 1'b0;
            blocked_d[si] = 1'b0;
            if (cur_hit) begin
              cur_valid_d = 1'b0;
              cur_slot_d  = '0;
            end
          end
        end
        pqrr_pkg::OP_SETPRIO: begin
          fail_d = !active || !preq_ok;
        end
        pqrr_pkg::OP_SWITCH, pqrr_pkg::OP_YIELD: begin
          fail_d = 1'b0;
          if (cur_valid_q) begin
            if (cur_running) begin
              ready_d[cur_slot_q] = 1'b1;
            end
          end else begin
            idle_ctx_d = ctx_q;
          end
          if (stat_o.need_search) begin
            base_d    = cur_valid_q ? cur_slot_q : '0;
            grp_d     = '0;
            quantum_d = 8'd0;
          end else begin
            quantum_d             = quantum_q - 8'd1;
            resume_d              = ctx_q;
            ready_d[cur_slot_q]   = 1'b0;
            blocked_d[cur_slot_q] = 1'b0;
          end
        end
        default: begin
          fail_d = !active;
        end
      endcase
    end

    if (cmd_i.search) begin
      if (found) begin
        cur_valid_d          = 1'b1;
        cur_slot_d           = found_idx;
        ready_d[found_idx]   = 1'b0;
        blocked_d[found_idx] = 1'b0;
      end else if (stat_o.last_group) begin
        cur_valid_d = 1'b0;
        cur_slot_d  = '0;
        quantum_d   = 8'd0;
        resume_d    = idle_ctx_q;
      end else begin
        grp_d = grp_q + pqrr_pkg::grp_t'(1);
      end
    end

    if (cmd_i.sel_load) begin
      quantum_d = qsat;
      resume_d  = ctx_rd;
    end

    if (cmd_i.respond) begin
      res_failed_d = fail_q;
      res_resume_d = resume_q;
      res_rvalid_d = cur_valid_q;
      res_rslot_d  = pqrr_pkg::slot_in_t'(cur_slot_q);
      res_active_d = active;
      if (!active) begin
        res_status_d = pqrr_pkg::ST_KILLED;
      end else if (ready_q[si]) begin
        res_status_d = pqrr_pkg::ST_READY;
      end else if (blocked_q[si]) begin
        res_status_d = pqrr_pkg::ST_BLOCKED;
      end else begin
        res_status_d = pqrr_pkg::ST_RUNNING;
      end
      res_prio_d = active ? prio_rd : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= pqrr_pkg::BEST_RST;
      worst_q     <= pqrr_pkg::WORST_RST;
      dflt_q      <= pqrr_pkg::DEFAULT_RST;
      valid_q     <= '0;
      ready_q     <= '0;
      blocked_q   <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      quantum_q   <= '0;
      idle_ctx_q  <= '0;
    end else begin
      best_q      <= best_d;
      worst_q     <= worst_d;
      dflt_q      <= dflt_d;
      valid_q     <= valid_d;
      ready_q     <= ready_d;
      blocked_q   <= blocked_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      quantum_q   <= quantum_d;
      idle_ctx_q  <= idle_ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= pqrr_pkg::op_e'(opcode_i);
      slot_q <= slot_i;
      preq_q <= priority_req_i;
      ctx_q  <= context_req_i;
    end
    base_q       <= base_d;
    grp_q        <= grp_d;
    fail_q       <= fail_d;
    resume_q     <= resume_d;
    res_failed_q <= res_failed_d;
    res_resume_q <= res_resume_d;
    res_rvalid_q <= res_rvalid_d;
    res_rslot_q  <= res_rslot_d;
    res_active_q <= res_active_d;
    res_status_q <= res_status_d;
    res_prio_q   <= res_prio_d;
  end

  assign failed_o         = res_failed_q;
  assign resume_context_o = res_resume_q;
  assign running_valid_o  = res_rvalid_q;
  assign running_slot_o   = res_rslot_q;
  assign slot_active_o    = res_active_q;
  assign slot_status_o    = res_status_q;
  assign slot_priority_o  = res_prio_q;

endmodule

@@ rtl/priority_quantum_round_robin_scheduler.sv @@
// Top level of the priority-quantum round-robin task scheduler.
// An item is taken when start is high and busy is low; its result appears on the
// result ports for one cycle with done_o, and the receiver cannot stall it, so it
// must take the result in that cycle. Create, block, unblock, kill, set priority,
// query, and a switch or yield that keeps the current task, go through the execute,
// output-read and respond states. A switch or yield that picks a new task scans the
// ready marks eight slots per cycle, in eight groups for 64 slots, then goes through
// select-read, select-load, output-read and respond (no ready slot: the last two).
// busy drops in the cycle done_o is high, so the next item can enter then.
// Configuration writes are always taken (cfg_ready_o is high) and must come while idle.
module priority_quantum_round_robin_scheduler (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               opcode_i,
  input  pqrr_pkg::slot_in_t       slot_i,
  input  pqrr_pkg::prio_t          priority_req_i,
  input  pqrr_pkg::ctx_t           context_req_i,
  output logic                     done_o,
  output logic                     failed_o,
  output pqrr_pkg::ctx_t           resume_context_o,
  output logic                     running_valid_o,
  output pqrr_pkg::slot_in_t       running_slot_o,
  output logic                     slot_active_o,
  output logic [1:0]               slot_status_o,
  output pqrr_pkg::prio_t          slot_priority_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  pqrr_pkg::cfg_idx_t       cfg_index_i,
  input  pqrr_pkg::prio_t          cfg_data_i
);

  pqrr_pkg::dp_cmd_t  cmd;
  pqrr_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pqrr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  pqrr_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .slot_i           (slot_i),
    .priority_req_i   (priority_req_i),
    .context_req_i    (context_req_i),
    .failed_o         (failed_o),
    .resume_context_o (resume_context_o),
    .running_valid_o  (running_valid_o),
    .running_slot_o   (running_slot_o),
    .slot_active_o    (slot_active_o),
    .slot_status_o    (slot_status_o),
    .slot_priority_o  (slot_priority_o)
  );

endmodule

@@ rtl/pqrr_checker.sv @@
// Port-level assertions for the scheduler, bound to the top level.
module pqrr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic               running_valid_o,
  input pqrr_pkg::slot_in_t running_slot_o,
  input logic               slot_active_o,
  input logic [1:0]         slot_status_o,
  input pqrr_pkg::prio_t    slot_priority_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !running_valid_o |-> running_slot_o == '0)
    else $error("running slot nonzero with no task running");

  a_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !slot_active_o |-> (slot_status_o == pqrr_pkg::ST_KILLED) &&
                                  (slot_priority_o == '0))
    else $error("inactive slot reports status or priority");

endmodule

bind priority_quantum_round_robin_scheduler pqrr_checker u_pqrr_checker (.*);
